/* sv/assert_macros.svh */
// assertion helpers used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("port check failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("port check failed");

`endif

/* sv/urta_pkg.sv */
// ----------------------------------------------------------------------------
// urta_pkg
// Shared types, constants and the digit-to-ASCII function of the radix
// converter.
// ----------------------------------------------------------------------------
package urta_pkg;

  // field widths
  localparam int VALUE_FIELD_W   = 32;
  localparam int CHAR_W          = 7;
  localparam int COUNT_W         = 4;
  localparam int DIGIT_W         = 4;
  localparam int VALUE_WIDTH_DEF = 32;

  // digit buffer sizing
  localparam int MAX_DIGITS = 11;
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);

  // reciprocal of ten: q = (v * RECIP) >> RECIP_SHIFT, exact for v < 2^32
  localparam int               RECIP_W     = 32;
  localparam int               RECIP_SHIFT = 35;
  localparam logic [RECIP_W-1:0] RECIP     = 32'hCCCC_CCCD;

  localparam logic [DIGIT_W-1:0] DEC_BASE = 4'd10;

  // ascii anchors
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;

  // radix mode codes
  typedef enum logic [1:0] {
    OP_DEC  = 2'd0,
    OP_OCT  = 2'd1,
    OP_HEXL = 2'd2,
    OP_HEXU = 2'd3
  } radix_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic dig;
    logic emit;
  } urta_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_dec;
    logic is_dec;
    logic collect_done;
    logic one_left;
  } urta_stat_t;

  // one digit to its ascii code
  function automatic logic [CHAR_W-1:0] ascii_of(input radix_t mode,
                                                 input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_BASE) begin
      res = ASCII_ZERO + CHAR_W'(d);
    end else if (mode == OP_HEXU) begin
      res = ASCII_UPPER_A + CHAR_W'(d - DEC_BASE);
    end else begin
      res = ASCII_LOWER_A + CHAR_W'(d - DEC_BASE);
    end
    return res;
  endfunction

endpackage

/* sv/urta_dp.sv */
// ----------------------------------------------------------------------------
// urta_dp
// Datapath: value register, reciprocal multiplier, digit buffer and the
// output word register.
// ----------------------------------------------------------------------------
module urta_dp import urta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic [1:0]               op,
  input  logic [VALUE_FIELD_W-1:0] value,
  input  urta_cmd_t                cmd,
  output urta_stat_t               stat,
  output logic [CHAR_W-1:0]        character,
  output logic [COUNT_W-1:0]       char_count,
  output logic                     last
);

  localparam int EW = (VALUE_WIDTH < VALUE_FIELD_W) ? VALUE_WIDTH : VALUE_FIELD_W;
  localparam int PW = EW + RECIP_W;
  localparam int QW = PW - RECIP_SHIFT;

  radix_t               mode;
  logic [EW-1:0]        v;
  logic [PW-1:0]        prod;
  logic [DIGIT_W-1:0]   dig_buf [MAX_DIGITS];
  logic [CNT_W-1:0]     n;
  logic [COUNT_W-1:0]   emit_cnt;

  logic [QW-1:0]        q;
  logic [EW-1:0]        q_ext;
  logic [EW-1:0]        q10;
  logic [EW-1:0]        rem_dec;
  logic [DIGIT_W-1:0]   digit;
  logic [EW-1:0]        v_next;
  logic [CNT_W-1:0]     n_next;
  logic [CNT_W-1:0]     n_dec;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     rd_idx;

  // quotient and remainder by ten from the registered product
  assign q       = prod[PW-1:RECIP_SHIFT];
  assign q_ext   = EW'(q);
  assign q10     = (q_ext << 3) + (q_ext << 1);
  assign rem_dec = v - q10;

  // next digit and what is left of the value
  always_comb begin
    unique case (mode) inside
      OP_DEC: begin
        digit  = rem_dec[DIGIT_W-1:0];
        v_next = q_ext;
      end
      OP_OCT: begin
        digit  = {1'b0, v[2:0]};
        v_next = v >> 3;
      end
      OP_HEXL, OP_HEXU: begin
        digit  = v[DIGIT_W-1:0];
        v_next = v >> 4;
      end
      default: begin
        digit  = v[DIGIT_W-1:0];
        v_next = v >> 4;
      end
    endcase
  end

  assign n_next = n + CNT_W'(1);
  assign n_dec  = n - CNT_W'(1);
  assign wr_idx = n[IDX_W-1:0];
  assign rd_idx = n_dec[IDX_W-1:0];

  // status toward the controller
  assign stat.in_dec       = (radix_t'(op) == OP_DEC);
  assign stat.is_dec       = (mode == OP_DEC);
  assign stat.collect_done = (v_next == '0) || (n_next == CNT_W'(MAX_DIGITS));
  assign stat.one_left     = (n == CNT_W'(1));

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= radix_t'(op);
      v        <= value[EW-1:0];
      n        <= '0;
      emit_cnt <= '0;
    end
    if (cmd.mul) begin
      prod <= PW'(v) * PW'(RECIP);
    end
    if (cmd.dig) begin
      dig_buf[wr_idx] <= digit;
      v               <= v_next;
      n               <= n_next;
    end
    if (cmd.emit) begin
      character  <= ascii_of(mode, dig_buf[rd_idx]);
      char_count <= emit_cnt + COUNT_W'(1);
      emit_cnt   <= emit_cnt + COUNT_W'(1);
      last       <= stat.one_left;
      n          <= n_dec;
    end
  end

endmodule

/* sv/urta_ctrl.sv */
// ----------------------------------------------------------------------------
// urta_ctrl
// Controller: sequences load, digit collection and emission, and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module urta_ctrl import urta_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  urta_stat_t stat,
  output urta_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIG,
    S_EMIT
  } state_t;

  state_t state;
  logic   out_take;

  // output register free or being drained
  assign out_take = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // commands
  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: cmd.load = in_valid;
      S_MUL:  cmd.mul  = 1'b1;
      S_DIG:  cmd.dig  = 1'b1;
      S_EMIT: cmd.emit = out_take;
      default: cmd = '0;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= stat.in_dec ? S_MUL : S_DIG;
          end
        end
        S_MUL: state <= S_DIG;
        S_DIG: begin
          if (stat.collect_done) begin
            state <= S_EMIT;
          end else begin
            state <= stat.is_dec ? S_MUL : S_DIG;
          end
        end
        S_EMIT: begin
          if (out_take && stat.one_left) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* sv/unsigned_radix_to_ascii_top.sv */
// digits are collected into the buffer, then emitted as words, most significant first
// one value at a time; a new value is taken once the last digit is in the output register
// each decimal digit takes a step in the reciprocal multiplier before it is collected
// reset: synchronous, clears controller state and output valid only
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii_top
// Converts an unsigned value to ASCII digits in decimal, octal or hex,
// most significant digit first, one word per digit.
// ----------------------------------------------------------------------------
module unsigned_radix_to_ascii_top import urta_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               op,
  input  logic [VALUE_FIELD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CHAR_W-1:0]        character,
  output logic [COUNT_W-1:0]       char_count,
  output logic                     last
);

  urta_cmd_t  cmd;
  urta_stat_t stat;

  // sequencing
  urta_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // digit extraction and output word
  urta_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .op         (op),
    .value      (value),
    .cmd        (cmd),
    .stat       (stat),
    .character  (character),
    .char_count (char_count),
    .last       (last)
  );

endmodule

/* sv/urta_check.sv */
// ----------------------------------------------------------------------------
// urta_check
// Port-level checks of the radix converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urta_check import urta_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic [CHAR_W-1:0]        character,
  input logic [COUNT_W-1:0]       char_count,
  input logic                     last
);

  logic char_ok;

  // digit characters only
  assign char_ok = (character >= 7'h30 && character <= 7'h39) ||
                   (character >= 7'h61 && character <= 7'h66) ||
                   (character >= 7'h41 && character <= 7'h46);

  // a stalled word stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)

  // a shown word is a digit with a nonzero count
  `ASSERT_SAME(a_char_legal, clk, rst, out_valid, char_ok && (char_count != '0))

  // no new value is taken while a digit run is still open
  `ASSERT_SAME(a_run_busy, clk, rst, out_valid && !last, in_stall)

  // an accepted value keeps the input side busy in the next cycle
  `ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && !in_stall, in_stall)

endmodule

bind unsigned_radix_to_ascii_top urta_check u_check (.*);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Checks the radix-to-ASCII converter word by word. Values go in through the
// valid/stall input port; a scoreboard predicts the digit words of each
// accepted value and compares them, in order, with the words that leave the
// output port. Directed corner values come first, then random values under
// three idling mixes.
// ----------------------------------------------------------------------------
module testbench import urta_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_WAIT  = 40;

  // one expected output word
  typedef struct {
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] cnt;
    logic               fin;
  } char_word_t;

  // predicts the digit words of each value and checks them in order
  class ascii_digit_board;
    char_word_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void note_value(radix_t mode, logic [VALUE_FIELD_W-1:0] v);
      logic [63:0]        rest;
      logic [4:0]         base;
      logic [DIGIT_W-1:0] digs [MAX_DIGITS];
      logic [DIGIT_W-1:0] d;
      char_word_t         w;
      int                 n;
      rest = 64'(v);
      if (VALUE_WIDTH_DEF < 64) rest = rest & ((64'd1 << VALUE_WIDTH_DEF) - 64'd1);
      case (mode)
        OP_DEC:  base = 5'd10;
        OP_OCT:  base = 5'd8;
        default: base = 5'd16;
      endcase
      // digits least significant first
      n = 0;
      do begin
        digs[n] = DIGIT_W'(rest % base);
        rest = rest / base;
        n++;
      end while (rest != 0 && n < MAX_DIGITS);
      // queue them most significant first
      for (int k = 0; k < n; k++) begin
        d = digs[n - 1 - k];
        if (d < 4'd10) w.ch = ASCII_ZERO + CHAR_W'(d);
        else if (mode == OP_HEXU) w.ch = ASCII_UPPER_A + CHAR_W'(d - 4'd10);
        else w.ch = ASCII_LOWER_A + CHAR_W'(d - 4'd10);
        w.cnt = COUNT_W'(k + 1);
        w.fin = (k == n - 1);
        expected_chars.push_back(w);
      end
    endfunction

    function void check_word(logic [CHAR_W-1:0] ch, logic [COUNT_W-1:0] cnt, logic fin);
      char_word_t w;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected word: character %h char_count %0d last %b",
                 $realtime, ch, cnt, fin);
        errors++;
        return;
      end
      w = expected_chars.pop_front();
      if (ch !== w.ch) begin
        $display("%0t: character mismatch: expected %h actual %h", $realtime, w.ch, ch);
        errors++;
      end
      if (cnt !== w.cnt) begin
        $display("%0t: char_count mismatch: expected %0d actual %0d", $realtime, w.cnt, cnt);
        errors++;
      end
      if (fin !== w.fin) begin
        $display("%0t: last mismatch: expected %b actual %b", $realtime, w.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  radix_t                   op;
  logic [VALUE_FIELD_W-1:0] value;
  logic                     out_valid;
  logic                     out_stall;
  logic [CHAR_W-1:0]        character;
  logic [COUNT_W-1:0]       char_count;
  logic                     last;

  ascii_digit_board board;
  int               send_idle_pct = 9;
  int               recv_idle_pct = 59;
  int               cycles = 0;

  unsigned_radix_to_ascii_top dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .char_count (char_count),
    .last       (last)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("unsigned_radix_to_ascii_top test failed");
      $finish;
    end
  end

  // output side: check accepted words, stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) board.check_word(character, char_count, last);
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // present one value, holding it until accepted
  task automatic send_value(input radix_t m, input logic [VALUE_FIELD_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= m;
    value    <= v;
    do @(posedge clk); while (in_stall);
    board.note_value(m, v);
  endtask

  // hold off the input until every expected word has come out
  task automatic drain_output();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // random value with a spread of magnitudes
  function automatic logic [VALUE_FIELD_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return VALUE_FIELD_W'($urandom_range(20));
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_value(radix_t'($urandom_range(3)), pick_value());
  endtask

  initial begin
    radix_t                   dir_op  [22];
    logic [VALUE_FIELD_W-1:0] dir_val [22];
    board = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    op        <= OP_DEC;
    value     <= '0;
    dir_op  = '{OP_DEC, OP_OCT, OP_HEXL, OP_HEXU,
                OP_DEC, OP_OCT, OP_HEXL, OP_HEXU,
                OP_HEXL, OP_HEXU, OP_DEC, OP_DEC, OP_DEC, OP_DEC,
                OP_OCT, OP_OCT, OP_OCT, OP_HEXL, OP_HEXU, OP_HEXU, OP_HEXL, OP_DEC};
    dir_val = '{32'd0, 32'd0, 32'd0, 32'd0,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFEDC_BA98, 32'h89AB_CDEF, 32'd9, 32'd10, 32'd1000000000, 32'd999999999,
                32'd7, 32'd8, 32'h4000_0000, 32'd15, 32'd16, 32'h8000_0000, 32'd1,
                32'h5555_5555};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corner values, then random under a slow receiver
    for (int i = 0; i < 22; i++) send_value(dir_op[i], dir_val[i]);
    send_random(75);
    drain_output();

    // slow sender, fast receiver
    send_idle_pct = 59;
    recv_idle_pct = 9;
    send_random(75);
    drain_output();

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(70);
    drain_output();

    repeat (SETTLE_WAIT) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("unsigned_radix_to_ascii_top test passed");
    end else begin
      $display("unsigned_radix_to_ascii_top test failed");
    end
    $finish;
  end

endmodule
